// ===== design/pgb_pkg.sv =====
`timescale 1ns / 1ps
package pgb_pkg;

    // field widths fixed by the item format
    localparam int VAL_W     = 32;
    localparam int FAC_W     = 16;
    localparam int SLOT_W    = 4;
    localparam int ACT_W     = 5;
    localparam int CFG_IDX_W = 2;

    // defaults for the top level parameters
    localparam int PARTICLES_DEF     = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int MAX_RESULTS       = 16;

    // shared multiplier widths: 33-bit signed value times 17-bit positive factor
    localparam int MUL_A_W = VAL_W + 1;
    localparam int PROD_W  = MUL_A_W + FAC_W + 1;
    localparam int SUM_W   = PROD_W + 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REST    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 2'd3;

    // configuration reset values
    localparam logic [ACT_W-1:0]        ACTIVE_RST  = 5'd16;
    localparam logic signed [VAL_W-1:0] GRAVITY_RST = -32'sd642908;
    localparam logic [FAC_W-1:0]        REST_RST    = 16'd47186;
    localparam logic signed [VAL_W-1:0] FLOOR_RST   = 32'sd0;

    // item modes
    localparam logic MODE_STEP = 1'b0;
    localparam logic MODE_LOAD = 1'b1;

    // one stored particle
    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] z;
        logic signed [VAL_W-1:0] vx;
        logic signed [VAL_W-1:0] vy;
        logic signed [VAL_W-1:0] vz;
    } t_particle;

    // clamp a wide signed value to the 32-bit range
    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SUM_W-1:0] v);
        logic signed [VAL_W-1:0] res;
        if (v[SUM_W-1:VAL_W-1] == '0 || v[SUM_W-1:VAL_W-1] == '1) begin
            res = v[VAL_W-1:0];
        end else if (v[SUM_W-1]) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

    // 32-bit value plus rounded product, saturated
    function automatic logic signed [VAL_W-1:0] add_sat(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [PROD_W-1:0] b);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        return sat_val(s);
    endfunction

endpackage

// ===== design/pgb_in_if.sv =====
`timescale 1ns / 1ps
interface pgb_in_if;
    import pgb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    mode;
    logic [FAC_W-1:0]        time_step;
    logic [SLOT_W-1:0]       load_index;
    logic signed [VAL_W-1:0] load_x;
    logic signed [VAL_W-1:0] load_y;
    logic signed [VAL_W-1:0] load_z;
    logic signed [VAL_W-1:0] load_vx;
    logic signed [VAL_W-1:0] load_vy;
    logic signed [VAL_W-1:0] load_vz;

    modport source (
        output valid, mode, time_step, load_index,
        output load_x, load_y, load_z, load_vx, load_vy, load_vz,
        input  ready
    );

    modport sink (
        input  valid, mode, time_step, load_index,
        input  load_x, load_y, load_z, load_vx, load_vy, load_vz,
        output ready
    );
endinterface

// ===== design/pgb_out_if.sv =====
`timescale 1ns / 1ps
interface pgb_out_if;
    import pgb_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SLOT_W-1:0]       out_index;
    logic signed [VAL_W-1:0] out_x;
    logic signed [VAL_W-1:0] out_y;
    logic signed [VAL_W-1:0] out_z;
    logic                    last_particle;

    modport source (
        output valid, out_index, out_x, out_y, out_z, last_particle,
        input  ready
    );

    modport sink (
        input  valid, out_index, out_x, out_y, out_z, last_particle,
        output ready
    );
endinterface

// ===== design/particle_gravity_bounce_step_core.sv =====
`timescale 1ns / 1ps
// load item: written to the store when accepted; the block stays ready for the next item
// step item over N active particles: busy until the last write-back; gravity product first,
// then per particle four passes of the shared multiplier, the bounce product drain, the
// write-back, held while the output is full, and one registered read of the particle memory
// zero time step or zero active count: accepted with no results
// reset (synchronous, active low) makes all particles read as zero and loads register defaults
module particle_gravity_bounce_step_core #(
    parameter int PARTICLES     = pgb_pkg::PARTICLES_DEF,
    parameter int FRACTION_BITS = pgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    pgb_in_if.sink                           i_in,
    pgb_out_if.source                        o_out,
    input  logic                             i_cfg_we,
    input  logic [pgb_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pgb_pkg::VAL_W-1:0]        i_cfg_data
);
    import pgb_pkg::*;

    localparam int AW      = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;
    localparam int MAX_CNT = (PARTICLES < MAX_RESULTS) ? PARTICLES : MAX_RESULTS;
    localparam int WORD_W  = $bits(t_particle);

    // sequencer codes
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_GRAV = 4'd1;
    localparam logic [3:0] S_GDV  = 4'd2;
    localparam logic [3:0] S_P0   = 4'd3;
    localparam logic [3:0] S_P1   = 4'd4;
    localparam logic [3:0] S_P2   = 4'd5;
    localparam logic [3:0] S_P3   = 4'd6;
    localparam logic [3:0] S_P4   = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;
    localparam logic [3:0] S_RD   = 4'd9;

    // configuration registers
    logic [ACT_W-1:0]        r_active;
    logic signed [VAL_W-1:0] r_gravity;
    logic [FAC_W-1:0]        r_rest;
    logic signed [VAL_W-1:0] r_floor;

    // control state
    logic [3:0]           r_state, n_state;
    logic [AW-1:0]        r_idx, n_idx;
    logic [ACT_W-1:0]     r_count, n_count;
    logic [PARTICLES-1:0] r_valid, n_valid;
    logic                 r_rd_ok;
    logic                 r_out_valid, n_out_valid;

    // working registers
    logic [FAC_W-1:0]         r_dt, n_dt;
    logic signed [PROD_W-1:0] r_gdv, n_gdv;
    logic signed [VAL_W-1:0]  r_x, n_x;
    logic signed [VAL_W-1:0]  r_y, n_y;
    logic signed [VAL_W-1:0]  r_z, n_z;
    logic signed [VAL_W-1:0]  r_vy, n_vy;
    logic                     r_bnc, n_bnc;

    // output register payload
    logic [SLOT_W-1:0]       r_out_index;
    logic signed [VAL_W-1:0] r_out_x;
    logic signed [VAL_W-1:0] r_out_y;
    logic signed [VAL_W-1:0] r_out_z;
    logic                    r_out_last;

    logic                     w_accept;
    logic                     w_slot_ok;
    logic                     w_load_we;
    logic [ACT_W-1:0]         w_count;
    logic                     w_last;
    logic                     w_wb_go;
    logic                     w_ram_we;
    logic [AW-1:0]            w_ram_waddr;
    t_particle                w_ram_wdata;
    logic [WORD_W-1:0]        w_ram_q;
    t_particle                w_rd;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic [FAC_W-1:0]         w_mul_b;
    logic signed [PROD_W-1:0] w_mul_p;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_slot_ok  = int'(i_in.load_index) < PARTICLES;
    assign w_load_we  = w_accept && (i_in.mode == MODE_LOAD) && w_slot_ok;
    assign w_count    = (r_active > ACT_W'(MAX_CNT)) ? ACT_W'(MAX_CNT) : r_active;
    assign w_last     = (ACT_W'(r_idx) + ACT_W'(1)) == r_count;
    assign w_wb_go    = (r_state == S_WB) && (!r_out_valid || o_out.ready);

    // never written slots read as zero
    assign w_rd = r_rd_ok ? t_particle'(w_ram_q) : '0;

    // memory write: load in idle, write-back during a step
    always_comb begin
        w_ram_we    = w_load_we || w_wb_go;
        w_ram_waddr = r_idx;
        w_ram_wdata = '{x: r_x, y: r_y, z: r_z, vx: w_rd.vx, vy: r_vy, vz: w_rd.vz};
        if (r_state == S_IDLE) begin
            w_ram_waddr = AW'(i_in.load_index);
            w_ram_wdata = '{x: i_in.load_x, y: i_in.load_y, z: i_in.load_z,
                            vx: i_in.load_vx, vy: i_in.load_vy, vz: i_in.load_vz};
        end
    end

    pgb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (PARTICLES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (WORD_W'(w_ram_wdata)),
        .i_raddr (r_idx),
        .o_rdata (w_ram_q)
    );

    // shared multiplier operand select
    always_comb begin
        w_mul_b = r_dt;
        case (r_state)
            S_GRAV:  w_mul_a = MUL_A_W'(r_gravity);
            S_P0:    w_mul_a = MUL_A_W'(w_rd.vx);
            S_P1:    w_mul_a = MUL_A_W'(r_vy);
            S_P2:    w_mul_a = MUL_A_W'(w_rd.vz);
            S_P3: begin
                w_mul_a = -$signed({r_vy[VAL_W-1], r_vy});
                w_mul_b = r_rest;
            end
            default: w_mul_a = '0;
        endcase
    end

    pgb_mul_round #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_count     = r_count;
        n_valid     = r_valid;
        n_out_valid = r_out_valid;
        n_dt        = r_dt;
        n_gdv       = r_gdv;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_vy        = r_vy;
        n_bnc       = r_bnc;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_load_we) begin
                    n_valid[AW'(i_in.load_index)] = 1'b1;
                end
                if (w_accept && (i_in.mode == MODE_STEP) && (i_in.time_step != '0) &&
                    (w_count != '0)) begin
                    n_dt    = i_in.time_step;
                    n_count = w_count;
                    n_idx   = '0;
                    n_state = S_GRAV;
                end
            end
            S_GRAV: n_state = S_GDV;
            S_GDV: begin
                n_gdv   = w_mul_p;
                n_state = S_P0;
            end
            // new vertical velocity
            S_P0: begin
                n_vy    = add_sat(w_rd.vy, r_gdv);
                n_state = S_P1;
            end
            S_P1: begin
                n_x     = add_sat(w_rd.x, w_mul_p);
                n_state = S_P2;
            end
            S_P2: begin
                n_y     = add_sat(w_rd.y, w_mul_p);
                n_state = S_P3;
            end
            // floor test
            S_P3: begin
                n_z   = add_sat(w_rd.z, w_mul_p);
                n_bnc = (r_y < r_floor);
                if (r_y < r_floor) begin
                    n_y = r_floor;
                end
                n_state = S_P4;
            end
            S_P4: begin
                if (r_bnc) begin
                    n_vy = add_sat('0, w_mul_p);
                end
                n_state = S_WB;
            end
            // write back and hand the result to the output register
            S_WB: begin
                if (w_wb_go) begin
                    n_valid[r_idx] = 1'b1;
                    n_out_valid    = 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_RD;
                    end
                end
            end
            S_RD: n_state = S_P0;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_count     <= '0;
            r_valid     <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_valid     <= n_valid;
            r_rd_ok     <= r_valid[r_idx];
            r_out_valid <= n_out_valid;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= ACTIVE_RST;
            r_gravity <= GRAVITY_RST;
            r_rest    <= REST_RST;
            r_floor   <= FLOOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE:  r_active  <= i_cfg_data[ACT_W-1:0];
                CFG_GRAVITY: r_gravity <= i_cfg_data;
                CFG_REST:    r_rest    <= i_cfg_data[FAC_W-1:0];
                CFG_FLOOR:   r_floor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        r_dt  <= n_dt;
        r_gdv <= n_gdv;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_vy  <= n_vy;
        r_bnc <= n_bnc;
        if (w_wb_go) begin
            r_out_index <= SLOT_W'(r_idx);
            r_out_x     <= r_x;
            r_out_y     <= r_y;
            r_out_z     <= r_z;
            r_out_last  <= w_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.out_index     = r_out_index;
    assign o_out.out_x         = r_out_x;
    assign o_out.out_y         = r_out_y;
    assign o_out.out_z         = r_out_z;
    assign o_out.last_particle = r_out_last;

    // a real step starts the gravity product
    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in.mode == MODE_STEP) && (i_in.time_step != '0) && (w_count != '0))
        |=> (r_state == S_GRAV))
        else $error("step item did not start the sequencer");

    // the last particle's write-back returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wb_go && w_last) |=> (r_state == S_IDLE))
        else $error("sequencer did not finish after the last particle");

    // slot counter stays inside the active range while busy
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (ACT_W'(r_idx) < r_count))
        else $error("particle index beyond active count");

    // a bounced particle sits on the floor, others are at or above it
    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_P4) |-> (r_bnc ? (r_y == r_floor) : (r_y >= r_floor)))
        else $error("floor clamp inconsistent");

endmodule

// ===== design/pgb_ram.sv =====
`timescale 1ns / 1ps
module pgb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/pgb_mul_round.sv =====
`timescale 1ns / 1ps
module pgb_mul_round #(
    parameter int FRACTION_BITS = pgb_pkg::FRACTION_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic signed [pgb_pkg::MUL_A_W-1:0] i_a,
    input  logic [pgb_pkg::FAC_W-1:0]          i_b,
    output logic signed [pgb_pkg::PROD_W-1:0]  o_p
);
    import pgb_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FRACTION_BITS - 1);

    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_rnd;
    logic signed [PROD_W-1:0] r_p;

    // exact product, then round to nearest with ties upward
    assign w_prod = i_a * $signed({1'b0, i_b});
    assign w_rnd  = w_prod + HALF;

    always_ff @(posedge i_clk) begin
        r_p <= w_rnd >>> FRACTION_BITS;
    end

    assign o_p = r_p;

endmodule

// ===== bench/particle_gravity_bounce_step_core_tb.sv =====
`timescale 1ns / 1ps
module particle_gravity_bounce_step_core_tb;
    import pgb_pkg::*;

    localparam int NPART      = PARTICLES_DEF;
    localparam int FRAC       = FRACTION_BITS_DEF;
    localparam int SETTLE_CYC = 20;
    localparam int HOLD_CYC   = 400;
    localparam int PHASES     = 6;
    localparam int PHASE_LEN  = 41;

    localparam logic signed [VAL_W-1:0] VMAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] VMIN = 32'sh80000000;

    // one input item
    typedef struct {
        logic                    mode;
        logic [FAC_W-1:0]        dt;
        logic [SLOT_W-1:0]       slot;
        logic signed [VAL_W-1:0] x, y, z, vx, vy, vz;
    } t_cmd;

    // one expected position result
    typedef struct {
        logic [SLOT_W-1:0]       idx;
        logic signed [VAL_W-1:0] x, y, z;
        logic                    last;
    } t_pos_rec;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [VAL_W-1:0] i_cfg_data;

    pgb_in_if  in_ch();
    pgb_out_if out_ch();

    particle_gravity_bounce_step_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow copy of the particle store and registers
    logic signed [VAL_W-1:0] px [NPART];
    logic signed [VAL_W-1:0] py [NPART];
    logic signed [VAL_W-1:0] pz [NPART];
    logic signed [VAL_W-1:0] pvx [NPART];
    logic signed [VAL_W-1:0] pvy [NPART];
    logic signed [VAL_W-1:0] pvz [NPART];
    logic [ACT_W-1:0]        act_reg;
    logic signed [VAL_W-1:0] grav_reg;
    logic [FAC_W-1:0]        rest_reg;
    logic signed [VAL_W-1:0] floor_reg;

    t_pos_rec pending_positions[$];
    int errors;
    bit idle_on;
    int hold_req;
    int hold_seen;
    int hold_left;
    int stall_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("particle_gravity_bounce_step_core_tb: done, errors");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] sat32(input longint v);
        if (v > longint'(VMAX)) return VMAX;
        if (v < longint'(VMIN)) return VMIN;
        return v[VAL_W-1:0];
    endfunction

    // product rounded to nearest, ties up
    function automatic longint mul_round(input longint value, input longint factor);
        longint p;
        p = value * factor + (64'sd1 <<< (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic logic signed [VAL_W-1:0] rand_near(input logic signed [VAL_W-1:0] base,
                                                          input int span_bits);
        logic signed [VAL_W-1:0] off;
        off = $signed($urandom) >>> (VAL_W - span_bits);
        return sat32(longint'(base) + longint'(off));
    endfunction

    function automatic logic signed [VAL_W-1:0] pick_wide();
        case ($urandom_range(0, 3))
            0: return VMAX;
            1: return VMIN;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic t_cmd make_load(input int slot, input logic signed [VAL_W-1:0] x, y, z,
                                       input logic signed [VAL_W-1:0] vx, vy, vz);
        t_cmd c;
        c.mode = MODE_LOAD;
        c.dt   = FAC_W'($urandom);
        c.slot = SLOT_W'(slot);
        c.x  = x;  c.y  = y;  c.z  = z;
        c.vx = vx; c.vy = vy; c.vz = vz;
        return c;
    endfunction

    // step item, unused load fields carry noise
    function automatic t_cmd make_step(input logic [FAC_W-1:0] dt);
        t_cmd c;
        c.mode = MODE_STEP;
        c.dt   = dt;
        c.slot = SLOT_W'($urandom);
        c.x  = $urandom; c.y  = $urandom; c.z  = $urandom;
        c.vx = $urandom; c.vy = $urandom; c.vz = $urandom;
        return c;
    endfunction

    // one time step over the active particles
    task automatic advance_particles(input logic [FAC_W-1:0] dt);
        int count;
        longint gdv;
        logic signed [VAL_W-1:0] nx, ny, nz, nvy;
        t_pos_rec r;
        count = (act_reg > NPART) ? NPART : act_reg;
        gdv = mul_round(longint'(grav_reg), longint'(dt));
        for (int i = 0; i < count; i++) begin
            nvy = sat32(longint'(pvy[i]) + gdv);
            nx  = sat32(longint'(px[i]) + mul_round(longint'(pvx[i]), longint'(dt)));
            ny  = sat32(longint'(py[i]) + mul_round(longint'(nvy), longint'(dt)));
            nz  = sat32(longint'(pz[i]) + mul_round(longint'(pvz[i]), longint'(dt)));
            // floor hit: clamp and bounce with loss
            if (ny < floor_reg) begin
                ny  = floor_reg;
                nvy = sat32(mul_round(-longint'(nvy), longint'(rest_reg)));
            end
            px[i] = nx; py[i] = ny; pz[i] = nz; pvy[i] = nvy;
            r.idx  = SLOT_W'(i);
            r.x    = nx; r.y = ny; r.z = nz;
            r.last = (i + 1 == count);
            pending_positions.push_back(r);
        end
    endtask

    task automatic track_item(input t_cmd c);
        if (c.mode == MODE_LOAD) begin
            if (c.slot < NPART) begin
                px[c.slot]  = c.x;  py[c.slot]  = c.y;  pz[c.slot]  = c.z;
                pvx[c.slot] = c.vx; pvy[c.slot] = c.vy; pvz[c.slot] = c.vz;
            end
        end else if (c.dt != '0) begin
            advance_particles(c.dt);
        end
    endtask

    // offer one item and wait for it to be taken
    task automatic send_item(input t_cmd c);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= c.mode;
        in_ch.time_step  <= c.dt;
        in_ch.load_index <= c.slot;
        in_ch.load_x     <= c.x;
        in_ch.load_y     <= c.y;
        in_ch.load_z     <= c.z;
        in_ch.load_vx    <= c.vx;
        in_ch.load_vy    <= c.vy;
        in_ch.load_vz    <= c.vz;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        track_item(c);
    endtask

    // stop offering, wait for all results, then let the block go quiet
    task automatic drain_and_idle();
        in_ch.valid <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    // write all four registers, block idle
    task automatic write_regs(input logic [VAL_W-1:0] act_word, grav_word, rest_word,
                              input logic [VAL_W-1:0] floor_word);
        logic [VAL_W-1:0] words [4];
        logic [CFG_IDX_W-1:0] idxs [4];
        words = '{act_word, grav_word, rest_word, floor_word};
        idxs  = '{CFG_ACTIVE, CFG_GRAVITY, CFG_REST, CFG_FLOOR};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= words[k];
            @(posedge i_clk);
            case (idxs[k])
                CFG_ACTIVE:  act_reg   = words[k][ACT_W-1:0];
                CFG_GRAVITY: grav_reg  = words[k];
                CFG_REST:    rest_reg  = words[k][FAC_W-1:0];
                CFG_FLOOR:   floor_reg = words[k];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // result side: random stalls, long hold-off on request, compare each item
    always @(posedge i_clk) begin
        t_pos_rec e;
        if (hold_req != hold_seen) begin
            hold_left = HOLD_CYC;
            hold_seen = hold_req;
        end
        if (i_rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (pending_positions.size() == 0) begin
                $display("%0t: unexpected item, slot %0d", $time, out_ch.out_index);
                errors++;
            end else begin
                e = pending_positions.pop_front();
                if (out_ch.out_index !== e.idx) begin
                    $display("%0t: out_index expected %0d actual %0d",
                             $time, e.idx, out_ch.out_index);
                    errors++;
                end
                if (out_ch.out_x !== e.x) begin
                    $display("%0t: out_x slot %0d expected %h actual %h",
                             $time, e.idx, e.x, out_ch.out_x);
                    errors++;
                end
                if (out_ch.out_y !== e.y) begin
                    $display("%0t: out_y slot %0d expected %h actual %h",
                             $time, e.idx, e.y, out_ch.out_y);
                    errors++;
                end
                if (out_ch.out_z !== e.z) begin
                    $display("%0t: out_z slot %0d expected %h actual %h",
                             $time, e.idx, e.z, out_ch.out_z);
                    errors++;
                end
                if (out_ch.last_particle !== e.last) begin
                    $display("%0t: last_particle slot %0d expected %b actual %b",
                             $time, e.idx, e.last, out_ch.last_particle);
                    errors++;
                end
            end
            stall_left = idle_on ? $urandom_range(0, 9) : 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // all-zero store under default registers: everything falls and bounces
    task automatic test_reset_defaults();
        send_item(make_step(16'hffff));
        send_item(make_step(16'd1));
    endtask

    // extreme positions and velocities, saturation and negation of the minimum
    task automatic test_load_extremes();
        send_item(make_load(0, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX));
        send_item(make_load(15, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN));
        send_item(make_load(1, 32'sd0, 32'sd65536, VMIN, VMIN, VMIN, VMAX));
        send_item(make_load(2, VMAX, VMIN, 32'sd0, VMAX, VMAX, VMIN));
        send_item(make_step(16'hffff));
    endtask

    // zero time step changes nothing; load ignores its time step
    task automatic test_zero_step();
        send_item(make_step(16'd0));
        send_item(make_load(3, 32'sd327680, 32'sd655360, -32'sd65536,
                            32'sd131072, -32'sd196608, 32'sd65536));
        send_item(make_step(16'd0));
    endtask

    // register extremes, active count zero and above the store size
    task automatic test_config_extremes();
        drain_and_idle();
        write_regs({27'($urandom_range(1, 1 << 26)), 5'd0}, VMAX, {16'hdead, 16'd0}, VMIN);
        send_item(make_step(16'd100));
        drain_and_idle();
        write_regs({27'h5a5a5a5, 5'd31}, VMAX, {16'hbeef, 16'hffff}, VMIN);
        send_item(make_step(16'hffff));
        drain_and_idle();
        write_regs(32'd1, VMIN, 32'd0, VMAX);
        send_item(make_step(16'hffff));
        drain_and_idle();
    endtask

    // result side holds off long while steps keep coming
    task automatic test_backpressure();
        write_regs(32'd16, GRAVITY_RST, 32'(REST_RST), FLOOR_RST);
        hold_req++;
        for (int k = 0; k < 4; k++) send_item(make_step(FAC_W'($urandom_range(1, 4000))));
        drain_and_idle();
    endtask

    // sender waits for every result before going on
    task automatic test_pause_drain();
        for (int k = 4; k < 7; k++)
            send_item(make_load(k, rand_near(0, 20), rand_near(0, 20), rand_near(0, 20),
                                rand_near(0, 18), rand_near(0, 18), rand_near(0, 18)));
        send_item(make_step(16'd6554));
        drain_and_idle();
        send_item(make_step(16'd6554));
        drain_and_idle();
    endtask

    // random phases, each under its own register setting
    task automatic test_random();
        logic [ACT_W-1:0]        act;
        logic signed [VAL_W-1:0] grav, flr;
        logic [FAC_W-1:0]        rest;
        int r;
        for (int ph = 0; ph < PHASES; ph++) begin
            drain_and_idle();
            case ($urandom_range(0, 9))
                0: act = 5'd0;
                1: act = 5'd1;
                2: act = 5'd16;
                3: act = ACT_W'($urandom_range(17, 31));
                default: act = ACT_W'($urandom_range(1, 16));
            endcase
            case ($urandom_range(0, 5))
                0: grav = VMAX;
                1: grav = VMIN;
                2: grav = $signed($urandom);
                default: grav = rand_near(GRAVITY_RST, 20);
            endcase
            case ($urandom_range(0, 5))
                0: rest = 16'd0;
                1: rest = 16'hffff;
                2: rest = FAC_W'($urandom);
                default: rest = FAC_W'($urandom_range(30000, 60000));
            endcase
            case ($urandom_range(0, 5))
                0: flr = VMAX;
                1: flr = VMIN;
                2: flr = $signed($urandom);
                default: flr = rand_near(0, 24);
            endcase
            write_regs({27'($urandom_range(0, (1 << 27) - 1)), act}, grav,
                       {16'($urandom_range(0, 65535)), rest}, flr);
            idle_on = (ph != 2) && (ph != 4);
            for (int n = 0; n < PHASE_LEN; n++) begin
                r = $urandom_range(0, 99);
                if (r < 25) begin
                    // plausible particle near the floor
                    send_item(make_load($urandom_range(0, 15), rand_near(0, 24),
                                        rand_near(floor_reg, 22), rand_near(0, 24),
                                        rand_near(0, 22), rand_near(0, 22),
                                        rand_near(0, 22)));
                end else if (r < 35) begin
                    send_item(make_load($urandom_range(0, 15), pick_wide(), pick_wide(),
                                        pick_wide(), pick_wide(), pick_wide(),
                                        pick_wide()));
                end else if (r < 40) begin
                    send_item(make_step(16'd0));
                end else if (r < 85) begin
                    send_item(make_step(FAC_W'($urandom_range(1, 8192))));
                end else begin
                    send_item(make_step(FAC_W'($urandom_range(1, 65535))));
                end
            end
        end
        idle_on = 1'b1;
    endtask

    // main sequence
    initial begin
        errors     = 0;
        idle_on    = 1'b1;
        hold_req   = 0;
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_ACTIVE;
        i_cfg_data   <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_STEP;
        in_ch.time_step  <= '0;
        in_ch.load_index <= '0;
        in_ch.load_x     <= '0;
        in_ch.load_y     <= '0;
        in_ch.load_z     <= '0;
        in_ch.load_vx    <= '0;
        in_ch.load_vy    <= '0;
        in_ch.load_vz    <= '0;
        act_reg   = ACTIVE_RST;
        grav_reg  = GRAVITY_RST;
        rest_reg  = REST_RST;
        floor_reg = FLOOR_RST;
        for (int i = 0; i < NPART; i++) begin
            px[i] = '0; py[i] = '0; pz[i] = '0;
            pvx[i] = '0; pvy[i] = '0; pvz[i] = '0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_load_extremes();
        test_zero_step();
        test_config_extremes();
        test_backpressure();
        test_pause_drain();
        test_random();

        drain_and_idle();
        if (pending_positions.size() != 0) begin
            $display("%0t: %0d items never arrived", $time, pending_positions.size());
            errors++;
        end
        if (errors == 0) begin
            $display("particle_gravity_bounce_step_core_tb: done, clean");
        end else begin
            $display("particle_gravity_bounce_step_core_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pgb_pkg.sv
design/pgb_in_if.sv
design/pgb_out_if.sv
design/pgb_ram.sv
design/pgb_mul_round.sv
design/particle_gravity_bounce_step_core.sv
bench/particle_gravity_bounce_step_core_tb.sv
